>>> hw/rtl/mcdtm_pkg.sv
// shared types and constants of the cache and dram timing model
package mcdtm_pkg;

  localparam int ADDR_W    = 32;
  localparam int TIME_W    = 32;
  localparam int TAG_W     = 28;
  localparam int ROW_W     = 26;
  localparam int OFF_BITS  = 4;
  localparam int ROW_SHIFT = 6;
  localparam int MAX_IB    = 9;
  localparam int RAW_SET_W = 9;
  localparam int IB_W      = 4;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [IB_W-1:0]  IB_RESET  = 4'd9;
  localparam logic [CFG_W-1:0] HIT_RESET = 8'd1;
  localparam logic [CFG_W-1:0] CAS_RESET = 8'd24;
  localparam logic [CFG_W-1:0] RAS_RESET = 8'd72;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INDEX_BITS = 2'd0,
    CFG_HIT_TIME   = 2'd1,
    CFG_CAS        = 2'd2,
    CFG_RAS        = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REQ_READ_A  = 2'd0,
    REQ_READ_B  = 2'd1,
    REQ_WRITE_C = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUOT,
    ST_READ,
    ST_LOOK
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic load_in;
    logic calc_q;
    logic rd_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/mcdtm_ram.sv
// generic single-write, single-read ram with registered read
module mcdtm_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/mcdtm_ctrl.sv
// controller state machine: clearing pass and per-access sequencing
module mcdtm_ctrl import mcdtm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_QUOT;
      ST_QUOT:  state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_LOOK;
      ST_LOOK:  if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr_en = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_QUOT:  cmd.calc_q = 1'b1;
      ST_READ:  cmd.rd_en  = 1'b1;
      ST_LOOK:  cmd.commit = sts.out_free;
      default:  cmd = '0;
    endcase
  end

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free) else $error("commit without free output slot");
  a_read_then_look: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> state_r == ST_LOOK) else $error("read not followed by lookup");
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == ST_QUOT) else $error("accept lost");

endmodule

>>> hw/rtl/mcdtm_dp.sv
// datapath: config registers, set index, cache store, dram timing, output register
module mcdtm_dp import mcdtm_pkg::*; #(
  parameter int CORES = 8,
  parameter int WAYS  = 4,
  parameter int SETS  = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [2:0]           in_core,
  input  logic [1:0]           in_req_type,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic [TIME_W-1:0]    in_issue_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic [TIME_W-1:0]    out_resume_time
);

  localparam int SAW   = $clog2(SETS);
  localparam int CAW   = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int DEPTH = CORES << SAW;
  localparam int RAW   = $clog2(DEPTH);
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W = TAG_W + 1;
  localparam int ROW_B = WAYS * ENT_W;
  localparam int SH    = 20;
  localparam int RECIP = ((1 << SH) + SETS - 1) / SETS;
  localparam int RC_W  = $clog2(RECIP + 1);
  localparam int PR_W  = RAW_SET_W + RC_W;

  // config
  logic [IB_W-1:0]  ib_r;
  logic [CFG_W-1:0] hit_time_r, cas_r, ras_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_r       <= IB_RESET;
      hit_time_r <= HIT_RESET;
      cas_r      <= CAS_RESET;
      ras_r      <= RAS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_INDEX_BITS: ib_r       <= cfg_wdata[IB_W-1:0];
        CFG_HIT_TIME:   hit_time_r <= cfg_wdata;
        CFG_CAS:        cas_r      <= cfg_wdata;
        CFG_RAS:        ras_r      <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // input word
  logic [2:0]        core_r;
  logic [1:0]        kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic [TIME_W-1:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      core_r <= in_core;
      kind_r <= in_req_type;
      addr_r <= in_address;
      now_r  <= in_issue_time;
    end
  end

  // index width clamped to 1..9
  logic [IB_W-1:0]      ib_c;
  logic [RAW_SET_W-1:0] set_raw;
  logic [TAG_W-1:0]     tag;
  logic [ROW_W-1:0]     row;

  always_comb begin
    if (ib_r == '0) begin
      ib_c = IB_W'(1);
    end else if (ib_r > IB_W'(MAX_IB)) begin
      ib_c = IB_W'(MAX_IB);
    end else begin
      ib_c = ib_r;
    end
    set_raw = RAW_SET_W'(addr_r >> OFF_BITS) &
              RAW_SET_W'((10'd1 << ib_c) - 10'd1);
    tag     = TAG_W'(addr_r >> (OFF_BITS + int'(ib_c)));
    row     = ROW_W'(addr_r >> ROW_SHIFT);
  end

  // set modulo SETS by reciprocal multiply, exact for 9-bit values
  logic [RAW_SET_W-1:0] q_r;
  logic [PR_W-1:0]      prod;
  logic [RAW_SET_W:0]   qs;
  logic [SAW-1:0]       set_mod;

  assign prod = PR_W'(set_raw) * PR_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.calc_q) begin
      q_r <= RAW_SET_W'(prod >> SH);
    end
  end

  assign qs      = (RAW_SET_W+1)'(q_r * (RAW_SET_W+1)'(SETS));
  assign set_mod = SAW'((RAW_SET_W+1)'(set_raw) - qs);

  logic [6:0]     core_e;
  logic [RAW-1:0] rd_addr;
  logic [RAW-1:0] row_addr_r;

  assign core_e  = 7'(core_r);
  assign rd_addr = RAW'({core_e[CAW-1:0], set_mod});

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      row_addr_r <= rd_addr;
    end
  end

  // clearing pass
  logic [RAW:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en && clr_cnt_r != (RAW+1)'(DEPTH)) begin
      clr_cnt_r <= clr_cnt_r + (RAW+1)'(1);
    end
  end

  assign sts.clr_done = (clr_cnt_r == (RAW+1)'(DEPTH - 1));

  // cache store
  logic             mem_we;
  logic [RAW-1:0]   mem_waddr;
  logic [ROW_B-1:0] mem_wdata, rdata, new_row;

  mcdtm_ram #(.W(ROW_B), .D(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // lookup
  logic hit;
  always_comb begin
    hit = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (rdata[w*ENT_W + TAG_W] && rdata[w*ENT_W +: TAG_W] == tag) begin
        hit = 1'b1;
      end
    end
  end

  // per-core fifo way pointers and dram state
  logic [WW-1:0]     fifo_r [CORES];
  logic [TIME_W-1:0] busy_r;
  logic [ROW_W-1:0]  open_row_r;
  logic              orv_r;

  logic              core_ok, active, miss, short_hit, row_open;
  logic [WW-1:0]     way;
  logic [TIME_W-1:0] b, base, resume, busy_nxt;
  logic [10:0]       addend;
  logic [9:0]        c2, c3;

  always_comb begin
    core_ok   = core_e < 7'(CORES);
    active    = core_ok && kind_r != REQ_UNUSED;
    miss      = active && !hit;
    short_hit = hit && kind_r != REQ_WRITE_C;
    way       = fifo_r[core_e[CAW-1:0]];
    b         = (busy_r <= now_r) ? now_r : busy_r;
    row_open  = orv_r && row == open_row_r;
    c2        = {1'b0, cas_r, 1'b0};
    c3        = c2 + 10'(cas_r);
    if (short_hit) begin
      base   = now_r;
      addend = 11'(hit_time_r) + 11'd1;
    end else begin
      base   = b;
      addend = ((kind_r == REQ_WRITE_C) ? 11'(c3) : 11'(c2)) +
               (row_open ? 11'd0 : 11'(ras_r)) +
               (hit ? 11'd0 : ((kind_r == REQ_READ_B) ? 11'd3 : 11'd2));
    end
    resume   = base + TIME_W'(addend);
    busy_nxt = short_hit ? b : resume;
    new_row  = rdata;
    new_row[way*ENT_W +: ENT_W] = {1'b1, tag};
  end

  always_comb begin
    if (cmd.clr_en) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r[RAW-1:0];
      mem_wdata = '0;
    end else begin
      mem_we    = cmd.commit && miss;
      mem_waddr = row_addr_r;
      mem_wdata = new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= '0;
      open_row_r <= '0;
      orv_r      <= 1'b0;
      for (int c = 0; c < CORES; c++) begin
        fifo_r[c] <= '0;
      end
    end else if (cmd.commit && active) begin
      busy_r <= busy_nxt;
      if (miss || (kind_r == REQ_WRITE_C && !row_open)) begin
        open_row_r <= row;
      end
      if (miss) begin
        orv_r <= 1'b1;
        fifo_r[core_e[CAW-1:0]] <= (way == WW'(WAYS - 1)) ? '0 : way + WW'(1);
      end
    end
  end

  // output register
  logic              out_valid_r;
  logic              out_hit_r;
  logic [TIME_W-1:0] out_time_r;

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r  <= core_ok && hit;
      out_time_r <= active ? resume : now_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_resume_time = out_time_r;

endmodule

>>> hw/rtl/multicore_cache_dram_timing_model.sv
// top level of the multicore cache and dram timing model
// result word follows accept through multiply, read and lookup/commit
// one access at a time: accept, set quotient, store read, lookup/commit; next accept follows commit
// a waiting result does not block the next accept; commit waits for a free output slot
// reset: synchronous active low; config and dram state return to defaults, then a
// clearing pass over CORES*2^clog2(SETS) rows zeroes the tag store before input is taken
module multicore_cache_dram_timing_model import mcdtm_pkg::*; #(
  parameter int CORES = 8,
  parameter int WAYS  = 4,
  parameter int SETS  = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_core,
  input  logic [1:0]           in_req_type,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic [TIME_W-1:0]    in_issue_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic [TIME_W-1:0]    out_resume_time
);

  cmd_t cmd;
  sts_t sts;

  mcdtm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mcdtm_dp #(.CORES(CORES), .WAYS(WAYS), .SETS(SETS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_core         (in_core),
    .in_req_type     (in_req_type),
    .in_address      (in_address),
    .in_issue_time   (in_issue_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_resume_time (out_resume_time)
  );

endmodule

>>> bench/testbench.sv
// testbench for the multicore cache and dram timing model: scoreboard, stimulus, checks
module testbench;
  import mcdtm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class access_scoreboard;
    logic [31:0] tags[8][4][512];
    bit          vld[8][4][512];
    int unsigned fifo_way[8];
    logic [31:0] dram_busy;
    logic [25:0] open_row;
    bit          row_valid;
    logic [3:0]  idx_bits;
    logic [7:0]  hit_cyc, cas_cyc, ras_cyc;
    bit          exp_hit[$];
    logic [31:0] exp_resume[$];
    int          errors;

    function new();
      for (int c = 0; c < 8; c++) begin
        fifo_way[c] = 0;
        for (int w = 0; w < 4; w++)
          for (int s = 0; s < 512; s++) begin
            tags[c][w][s] = '0;
            vld[c][w][s] = 0;
          end
      end
      dram_busy = '0;
      open_row = '0;
      row_valid = 0;
      idx_bits = IB_RESET;
      hit_cyc = HIT_RESET;
      cas_cyc = CAS_RESET;
      ras_cyc = RAS_RESET;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [7:0] v);
      case (r)
        CFG_INDEX_BITS: idx_bits = v[3:0];
        CFG_HIT_TIME:   hit_cyc = v;
        CFG_CAS:        cas_cyc = v;
        CFG_RAS:        ras_cyc = v;
        default:        ;
      endcase
    endfunction

    function int pending();
      return exp_hit.size();
    endfunction

    // work out timing and cache update for one accepted word
    function void note_access(logic [2:0] core, req_t kind, logic [31:0] addr,
                              logic [31:0] now);
      int unsigned ib, set_i, w;
      logic [31:0] tag, resume, ras;
      logic [25:0] row;
      bit hit, row_hit;
      ib = idx_bits;
      if (ib < 1) ib = 1;
      if (ib > MAX_IB) ib = MAX_IB;
      set_i = ((addr >> OFF_BITS) & ((32'd1 << ib) - 1)) % 512;
      tag = addr >> (OFF_BITS + ib);
      row = addr >> ROW_SHIFT;
      hit = 0;
      for (int i = 0; i < 4; i++)
        if (vld[core][i][set_i] && tags[core][i][set_i] == tag) hit = 1;
      if (kind == REQ_UNUSED) begin
        exp_hit.push_back(hit);
        exp_resume.push_back(now);
        return;
      end
      if (dram_busy <= now) dram_busy = now;
      row_hit = row_valid && (row == open_row);
      ras = row_hit ? 32'd0 : 32'(ras_cyc);
      if (hit) begin
        if (kind == REQ_WRITE_C) begin
          resume = dram_busy + 3 * 32'(cas_cyc) + ras;
          if (!row_hit) open_row = row;
          dram_busy = resume;
        end else begin
          resume = now + 32'(hit_cyc) + 1;
        end
      end else begin
        resume = dram_busy + 2 * 32'(cas_cyc) + ras + ((kind == REQ_READ_B) ? 3 : 2);
        if (kind == REQ_WRITE_C) resume += 32'(cas_cyc);
        open_row = row;
        row_valid = 1;
        w = fifo_way[core] % 4;
        vld[core][w][set_i] = 1;
        tags[core][w][set_i] = tag;
        fifo_way[core] = (w < 3) ? w + 1 : 0;
        dram_busy = resume;
      end
      exp_hit.push_back(hit);
      exp_resume.push_back(resume);
    endfunction

    function void check_result(bit h, logic [31:0] t);
      bit eh;
      logic [31:0] et;
      if (exp_hit.size() == 0) begin
        $display("%0t: unexpected result word hit=%0d resume=%0h", $time, h, t);
        errors++;
        return;
      end
      eh = exp_hit.pop_front();
      et = exp_resume.pop_front();
      if (h !== eh) begin
        $display("%0t: hit mismatch expected %0d actual %0d", $time, eh, h);
        errors++;
      end
      if (t !== et) begin
        $display("%0t: resume_time mismatch expected %0h actual %0h", $time, et, t);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 0;
  logic              in_ready;
  logic [2:0]        in_core = '0;
  logic [1:0]        in_req_type = '0;
  logic [ADDR_W-1:0] in_address = '0;
  logic [TIME_W-1:0] in_issue_time = '0;
  logic              out_valid;
  logic              out_ready = 0;
  logic              out_hit;
  logic [TIME_W-1:0] out_resume_time;

  access_scoreboard sb = new();
  logic [31:0] clock_now = '0;
  logic [31:0] addr_pool[32];
  int          burst_left = 0;
  int          stall_left = 0;
  bit          stall_on = 0;

  multicore_cache_dram_timing_model uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: random stall and free stretches of random length
  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_result(out_hit, out_resume_time);
    if (stall_left == 0) begin
      stall_on = ($urandom_range(0, 2) == 0);
      stall_left = stall_on ? $urandom_range(1, 6) : $urandom_range(1, 40);
    end
    stall_left--;
    out_ready <= !stall_on;
  end

  task automatic send_word(logic [2:0] core, req_t kind, logic [31:0] addr,
                           logic [31:0] now);
    in_valid <= 1;
    in_core <= core;
    in_req_type <= kind;
    in_address <= addr;
    in_issue_time <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_access(core, kind, addr, now);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(logic [3:0] ib, logic [7:0] ht, logic [7:0] cas,
                            logic [7:0] ras);
    cfg_reg_t r;
    logic [7:0] v[4];
    v = '{8'(ib), ht, cas, ras};
    for (int i = 0; i < 4; i++) begin
      r = cfg_reg_t'(i);
      cfg_we <= 1;
      cfg_index <= r;
      cfg_wdata <= v[i];
      sb.set_reg(r, v[i]);
      @(posedge clk);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic timed_send(logic [2:0] core, req_t kind, logic [31:0] addr);
    clock_now += $urandom_range(0, 150);
    send_word(core, kind, addr, clock_now);
  endtask

  task automatic random_phase(int n);
    logic [31:0] a;
    int k;
    for (int i = 0; i < 32; i++)
      addr_pool[i] = ($urandom_range(0, 7) << 13) | ($urandom_range(0, 3) << 4)
                     | $urandom_range(0, 15) | (($urandom_range(0, 3) == 0) ? $urandom << 16 : 0);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      a = (k < 8) ? addr_pool[$urandom_range(0, 31)] : $urandom;
      timed_send(3'($urandom_range(0, 7)), req_t'($urandom_range(0, 3)), a);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: reset config, extremes, every kind, c hit after the row moved
    send_word(3'd0, REQ_READ_A, 32'h0, 32'h0);
    send_word(3'd0, REQ_READ_A, 32'h0, 32'h0);
    send_word(3'd0, REQ_READ_B, 32'h0000_0004, 32'd5);
    send_word(3'd0, REQ_READ_A, 32'h0000_1000, 32'd6);
    send_word(3'd0, REQ_WRITE_C, 32'h0, 32'd7);
    send_word(3'd0, REQ_WRITE_C, 32'h0000_0020, 32'd8);
    send_word(3'd0, REQ_UNUSED, 32'h0, 32'd9);
    send_word(3'd0, REQ_UNUSED, 32'h1234_5670, 32'd10);
    send_word(3'd7, REQ_READ_B, 32'hFFFF_FFFF, 32'd400);
    send_word(3'd7, REQ_READ_B, 32'hFFFF_FFFF, 32'd401);
    send_word(3'd7, REQ_WRITE_C, 32'hFFFF_FFF0, 32'd402);
    send_word(3'd7, REQ_UNUSED, 32'hFFFF_FFFF, 32'd403);
    for (int i = 0; i < 5; i++) send_word(3'd3, REQ_READ_A, 32'(i) << 13, 32'd500 + i);
    send_word(3'd3, REQ_READ_A, 32'h0, 32'd600);
    send_word(3'd5, REQ_WRITE_C, 32'hABCD_0000, 32'hFFFF_FFF0);
    send_word(3'd5, REQ_READ_A, 32'hABCD_0000, 32'hFFFF_FFFF);
    send_word(3'd5, REQ_READ_A, 32'h5555_AAAA, 32'hFFFF_FFFF);
    clock_now = 32'hFFFF_FFFF;
    random_phase(230);
    drain();
    write_regs(4'd1, 8'd0, 8'd0, 8'd0);
    random_phase(220);
    drain();
    write_regs(4'd15, 8'd255, 8'd255, 8'd255);
    random_phase(220);
    drain();
    write_regs(4'd0, 8'd7, 8'd3, 8'd200);
    random_phase(200);
    drain();
    write_regs(4'd5, 8'($urandom), 8'($urandom), 8'($urandom));
    clock_now = $urandom;
    random_phase(200);
    drain();
    write_regs(4'd9, 8'd1, 8'd24, 8'd72);
    random_phase(200);
    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
